// File: sv/arsl_pkg.sv
`default_nettype none
package arsl_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int TAG_W       = 16;

   localparam int ADDR_W    = 64;
   localparam int SIZE_W    = 32;
   localparam int IN_TAG_W  = 16;
   localparam int OUT_TAG_W = 16;
   localparam int OUT_CNT_W = 7;
   localparam int CMD_W     = 2;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [SIZE_W-1:0] size;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_WRITE,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic             req_valid;
      logic [CMD_W-1:0] req_cmd;
      logic [CMD_W-1:0] cmd;
      logic             full;
      logic             bound_done;
      logic             shift_more;
      logic             rsp_ready;
   } ctrl_in_type;

   typedef struct packed {
      logic req_ready;
      logic rsp_valid;
      logic probe_rd;
      logic cmp_en;
      logic shift_rd;
      logic shift_wr;
      logic new_wr;
      logic query_done;
   } ctrl_out_type;

endpackage
`default_nettype wire

// File: sv/arsl_ram.sv
`default_nettype none
module arsl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: sv/arsl_ctrl.sv
`default_nettype none
module arsl_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire arsl_pkg::ctrl_in_type ctrl_in,
   output      arsl_pkg::ctrl_out_type ctrl_out
);
   import arsl_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (ctrl_in.req_valid) begin
               case (ctrl_in.req_cmd)
                  CMD_INSERT: state_in = ctrl_in.full ? ST_RESULT : ST_SEARCH;
                  CMD_QUERY:  state_in = ST_SEARCH;
                  default:    state_in = ST_RESULT;
               endcase
            end
         end
         ST_SEARCH: begin
            if (!ctrl_in.bound_done) begin
               state_in = ST_CMP;
            end else if (ctrl_in.cmd == CMD_INSERT) begin
               state_in = ST_SHIFT_RD;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_CMP:      state_in = ST_SEARCH;
         ST_SHIFT_RD: state_in = ctrl_in.shift_more ? ST_SHIFT_WR : ST_WRITE;
         ST_SHIFT_WR: state_in = ST_SHIFT_RD;
         ST_WRITE:    state_in = ST_RESULT;
         ST_RESULT: begin
            if (ctrl_in.rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl_out = '0;
      unique case (state_ff)
         ST_IDLE:     ctrl_out.req_ready = 1'b1;
         ST_SEARCH: begin
            ctrl_out.probe_rd   = !ctrl_in.bound_done;
            ctrl_out.query_done = ctrl_in.bound_done && (ctrl_in.cmd == CMD_QUERY);
         end
         ST_CMP:      ctrl_out.cmp_en = 1'b1;
         ST_SHIFT_RD: ctrl_out.shift_rd = ctrl_in.shift_more;
         ST_SHIFT_WR: ctrl_out.shift_wr = 1'b1;
         ST_WRITE:    ctrl_out.new_wr = 1'b1;
         ST_RESULT:   ctrl_out.rsp_valid = 1'b1;
         default:     ctrl_out = '0;
      endcase
   end

endmodule
`default_nettype wire

// File: sv/address_range_symbol_lookup.sv
`default_nettype none
// channel   handshake              payload
// req_      req_valid/req_ready    req_cmd, req_address, req_region_size, req_region_tag
// rsp_      rsp_valid/rsp_ready    rsp_status, rsp_hit, rsp_found_tag, rsp_offset,
//                                  rsp_entry_count
//
// one transaction at a time; a query makes k binary search probes before its response
// (at most ceil(log2(n+1)) for n stored regions), each a table read and then a compare
// an insert searches in the same way, then moves m entries up one slot and writes the new one,
// every move being a read and a write through the single table memory
// clear, an unused command and an insert into a full table respond without any search
// synchronous reset empties the table; the response holds until rsp_ready
module address_range_symbol_lookup (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic [arsl_pkg::CMD_W-1:0]      req_cmd,
   input  wire logic [arsl_pkg::ADDR_W-1:0]     req_address,
   input  wire logic [arsl_pkg::SIZE_W-1:0]     req_region_size,
   input  wire logic [arsl_pkg::IN_TAG_W-1:0]   req_region_tag,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic                            rsp_status,
   output      logic                            rsp_hit,
   output      logic [arsl_pkg::OUT_TAG_W-1:0]  rsp_found_tag,
   output      logic [arsl_pkg::SIZE_W-1:0]     rsp_offset,
   output      logic [arsl_pkg::OUT_CNT_W-1:0]  rsp_entry_count
);
   import arsl_pkg::*;

   ctrl_in_type  ctrl_in;
   ctrl_out_type ctrl;

   logic [CMD_W-1:0]     cmd_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic [SIZE_W-1:0]    size_ff;
   logic [TAG_W-1:0]     tag_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     lo_ff;
   logic [CNT_W-1:0]     hi_ff;
   logic [CNT_W-1:0]     j_ff;
   entry_type            lo_ent_ff;
   entry_type            hi_ent_ff;
   logic                 hi_eq_ff;
   logic                 status_ff;
   logic                 hit_ff;
   logic [OUT_TAG_W-1:0] found_tag_ff;
   logic [SIZE_W-1:0]    offset_ff;

   logic                 req_fire;
   logic [CNT_W:0]       mid_sum;
   logic [CNT_W-1:0]     mid;
   logic [CNT_W-1:0]     j_dec;
   entry_type            rd_ent;
   logic [ENTRY_W-1:0]   rd_data;
   logic                 go_right;
   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_wr_addr;
   entry_type            ram_wr_ent;
   logic                 ram_rd_en;
   logic [IDX_W-1:0]     ram_rd_addr;
   logic                 sel_hi;
   logic                 sel_ok;
   entry_type            sel_ent;
   logic [ADDR_W:0]      diff;
   logic                 in_region;

   assign req_fire = req_valid && ctrl.req_ready;

   assign ctrl_in.req_valid  = req_valid;
   assign ctrl_in.req_cmd    = req_cmd;
   assign ctrl_in.cmd        = cmd_ff;
   assign ctrl_in.full       = (count_ff == CNT_W'(TABLE_DEPTH));
   assign ctrl_in.bound_done = (lo_ff == hi_ff);
   assign ctrl_in.shift_more = (j_ff > lo_ff);
   assign ctrl_in.rsp_ready  = rsp_ready;

   arsl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .ctrl_in  (ctrl_in),
      .ctrl_out (ctrl)
   );

   // search midpoint and shift source
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[CNT_W:1];
   assign j_dec   = j_ff - CNT_W'(1);

   assign ram_rd_en   = ctrl.probe_rd || ctrl.shift_rd;
   assign ram_rd_addr = ctrl.shift_rd ? j_dec[IDX_W-1:0] : mid[IDX_W-1:0];

   assign ram_wr_en   = ctrl.shift_wr || ctrl.new_wr;
   assign ram_wr_addr = ctrl.new_wr ? lo_ff[IDX_W-1:0] : j_ff[IDX_W-1:0];

   always_comb begin
      if (ctrl.new_wr) begin
         ram_wr_ent.start = addr_ff;
         ram_wr_ent.size  = size_ff;
         ram_wr_ent.tag   = tag_ff;
      end else begin
         ram_wr_ent = rd_ent;
      end
   end

   arsl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_ent),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_data)
   );

   assign rd_ent = rd_data;

   // insert looks for the upper bound, query for the lower bound
   assign go_right = (cmd_ff == CMD_INSERT) ? (rd_ent.start <= addr_ff)
                                            : (rd_ent.start < addr_ff);

   // exact match at the lower bound wins, else the entry just below it
   assign sel_hi    = (hi_ff != count_ff) && hi_eq_ff;
   assign sel_ok    = sel_hi || (lo_ff != '0);
   assign sel_ent   = sel_hi ? hi_ent_ff : lo_ent_ff;
   assign diff      = {1'b0, addr_ff} - {1'b0, sel_ent.start};
   assign in_region = sel_ok && !diff[ADDR_W] && (diff[ADDR_W-1:SIZE_W] == '0)
                      && (diff[SIZE_W-1:0] < sel_ent.size);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (req_fire && (req_cmd == CMD_CLEAR)) begin
         count_ff <= '0;
      end else if (ctrl.new_wr) begin
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff       <= req_cmd;
         addr_ff      <= req_address;
         size_ff      <= req_region_size;
         tag_ff       <= TAG_W'(req_region_tag);
         lo_ff        <= '0;
         hi_ff        <= count_ff;
         j_ff         <= count_ff;
         status_ff    <= (req_cmd == CMD_INSERT) && ctrl_in.full;
         hit_ff       <= 1'b0;
         found_tag_ff <= '0;
         offset_ff    <= '0;
      end
      if (ctrl.cmp_en) begin
         if (go_right) begin
            lo_ff     <= mid + CNT_W'(1);
            lo_ent_ff <= rd_ent;
         end else begin
            hi_ff     <= mid;
            hi_ent_ff <= rd_ent;
            hi_eq_ff  <= (rd_ent.start == addr_ff);
         end
      end
      if (ctrl.shift_wr) begin
         j_ff <= j_dec;
      end
      if (ctrl.query_done && in_region) begin
         hit_ff       <= 1'b1;
         found_tag_ff <= OUT_TAG_W'(sel_ent.tag);
         offset_ff    <= diff[SIZE_W-1:0];
      end
   end

   assign req_ready       = ctrl.req_ready;
   assign rsp_valid       = ctrl.rsp_valid;
   assign rsp_status      = status_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_found_tag   = found_tag_ff;
   assign rsp_offset      = offset_ff;
   assign rsp_entry_count = OUT_CNT_W'(count_ff);

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("stored count beyond table depth");

   a_no_write_full: assert property (@(posedge clock) disable iff (reset)
      ctrl.new_wr |-> count_ff < CNT_W'(TABLE_DEPTH))
      else $error("region written into full table");

   a_search_order: assert property (@(posedge clock) disable iff (reset)
      (ctrl.probe_rd || ctrl.cmp_en) |-> (lo_ff < hi_ff) && (hi_ff <= count_ff))
      else $error("search bounds out of order");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request accepted while response pending");
`endif

endmodule
`default_nettype wire
